@@ hdl/rational_arithmetic_unit_macros.svh @@
// assertion macros for the rational arithmetic unit
// no dependencies
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`ifndef SYNTH
`define RAU_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("assertion failed");
`define RAU_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("assertion failed");
`else
`define RAU_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define RAU_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

@@ hdl/rau_pkg.sv @@
// package for the rational arithmetic unit: command codes and shared types
// no dependencies
package rau_pkg;
  localparam int unsigned NumW = 64;
  localparam int unsigned DenW = 62;
  localparam int unsigned MulW = 32;
  localparam int unsigned CmdW = 3;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_CMP = 3'd4
  } cmd_t;

  // request to the shared divider
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [63:0] rem;
  } div_rsp_t;
endpackage

@@ hdl/rational_arithmetic_unit.sv @@
// rational arithmetic unit top level: sequencer around a shared multiplier and divider
// depends on rau_pkg, rau_mult, rau_div and rational_arithmetic_unit_macros.svh
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | command, two fractions
//  out_    | output    | out_valid / out_ready | reduced fraction, greater, error
//
// sequence: four multiplies, then a euclidean gcd with one divide per
// remainder step (up to about 92 steps), then two exact divides; compare,
// divide by zero and unused commands skip the gcd and the divides and go
// straight to the output
// reset: synchronous active low, clears the sequencer only
// stalls: in_ready is high only when idle; the result waits in out_ registers
`include "rational_arithmetic_unit_macros.svh"
module rational_arithmetic_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic signed [31:0] in_first_num,
  input  logic [30:0] in_first_den,
  input  logic signed [31:0] in_second_num,
  input  logic [30:0] in_second_den,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [63:0] out_result_num,
  output logic [61:0] out_result_den,
  output logic        out_greater,
  output logic        out_error
);
  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_COMB, S_GCD, S_DN, S_DD, S_OUT
  } state_t;

  state_t state_r;
  logic [2:0]  cmd_r;
  logic [31:0] an_r, bn_r;       // magnitudes
  logic        an_s_r, bn_s_r;   // signs
  logic [30:0] ad_r, bd_r;
  logic [63:0] p_r [4];          // products: |an|*bd, |bn|*ad, ad*bd, |an|*|bn|
  logic [63:0] mag_r, den_r, gx_r, gy_r, g_r;
  logic        neg_r;
  logic        mstart, mdone;
  logic [31:0] ma, mb;
  logic [63:0] mprod;
  rau_pkg::div_req_t dreq;
  rau_pkg::div_rsp_t drsp;
  logic        wait_r;

  // combine stage signals
  logic signed [64:0] t1, t2, sum;
  logic        cmp_gt;

  rau_mult u_mult (.clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb),
                   .done(mdone), .prod(mprod));
  rau_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_ready = (state_r == S_IDLE);

  // operand selection for the multiplier
  always_comb begin
    unique case (state_r)
      S_M0:    begin ma = an_r;         mb = {1'b0, bd_r}; end
      S_M1:    begin ma = bn_r;         mb = {1'b0, ad_r}; end
      S_M2:    begin ma = {1'b0, ad_r}; mb = {1'b0, bd_r}; end
      default: begin ma = an_r;         mb = bn_r;         end
    endcase
  end
  assign mstart = !wait_r && (state_r == S_M0 || state_r == S_M1 ||
                              state_r == S_M2 || state_r == S_M3);

  // signed cross terms
  always_comb begin
    t1 = an_s_r ? -$signed({1'b0, p_r[0]}) : $signed({1'b0, p_r[0]});
    t2 = bn_s_r ? -$signed({1'b0, p_r[1]}) : $signed({1'b0, p_r[1]});
    unique case (cmd_r)
      rau_pkg::CMD_SUB: sum = t1 - t2;
      default:          sum = t1 + t2;
    endcase
    cmp_gt = (t1 > t2);
  end

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = gx_r;
    dreq.divisor  = gy_r;
    if (!wait_r) begin
      unique case (state_r)
        S_GCD:   dreq.start = (gy_r != 64'd0);
        S_DN:    begin dreq.start = 1'b1; dreq.dividend = mag_r; dreq.divisor = g_r; end
        S_DD:    begin dreq.start = 1'b1; dreq.dividend = den_r; dreq.divisor = g_r; end
        default: dreq.start = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      wait_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r  <= in_command;
            an_s_r <= in_first_num[31];
            bn_s_r <= in_second_num[31];
            an_r   <= in_first_num[31] ? -in_first_num : in_first_num;
            bn_r   <= in_second_num[31] ? -in_second_num : in_second_num;
            ad_r   <= (in_first_den == '0) ? 31'd1 : in_first_den;
            bd_r   <= (in_second_den == '0) ? 31'd1 : in_second_den;
            wait_r <= 1'b0;
            state_r <= S_M0;
          end
        end
        S_M0, S_M1, S_M2, S_M3: begin
          if (!wait_r) begin
            wait_r <= 1'b1;
          end else if (mdone) begin
            wait_r <= 1'b0;
            unique case (state_r)
              S_M0:    begin p_r[0] <= mprod; state_r <= S_M1; end
              S_M1:    begin p_r[1] <= mprod; state_r <= S_M2; end
              S_M2:    begin p_r[2] <= mprod; state_r <= S_M3; end
              default: begin p_r[3] <= mprod; state_r <= S_COMB; end
            endcase
          end
        end
        S_COMB: begin
          out_greater    <= 1'b0;
          out_error      <= 1'b0;
          out_result_num <= 64'sd0;
          out_result_den <= 62'd1;
          den_r          <= p_r[2];
          state_r        <= S_GCD;
          unique case (cmd_r)
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
              neg_r <= sum[64];
              mag_r <= sum[64] ? 64'(-sum) : sum[63:0];
            end
            rau_pkg::CMD_MUL: begin
              neg_r <= an_s_r ^ bn_s_r;
              mag_r <= p_r[3];
            end
            rau_pkg::CMD_DIV: begin
              neg_r <= an_s_r ^ bn_s_r;
              mag_r <= p_r[0];
              den_r <= p_r[1];
              if (bn_r == 32'd0) begin
                out_error <= 1'b1;
                state_r   <= S_OUT;
              end
            end
            rau_pkg::CMD_CMP: begin
              out_greater <= cmp_gt;
              state_r     <= S_OUT;
            end
            default: state_r <= S_OUT;
          endcase
          gx_r <= '0;
          gy_r <= '0;
          wait_r <= 1'b1; // load gcd operands next cycle
        end
        S_GCD: begin
          if (wait_r && gx_r == 64'd0 && gy_r == 64'd0 && !drsp.done) begin
            gx_r   <= mag_r;
            gy_r   <= den_r;
            wait_r <= 1'b0;
          end else if (!wait_r) begin
            if (gy_r == 64'd0) begin
              g_r     <= (gx_r == 64'd0) ? 64'd1 : gx_r;
              state_r <= S_DN;
            end else begin
              wait_r <= 1'b1;
            end
          end else if (drsp.done) begin
            gx_r   <= gy_r;
            gy_r   <= drsp.rem;
            wait_r <= 1'b0;
          end
        end
        S_DN: begin
          if (!wait_r) begin
            wait_r <= 1'b1;
          end else if (drsp.done) begin
            mag_r   <= drsp.quot;
            wait_r  <= 1'b0;
            state_r <= S_DD;
          end
        end
        S_DD: begin
          if (!wait_r) begin
            wait_r <= 1'b1;
          end else if (drsp.done) begin
            out_result_num <= neg_r ? -mag_r : mag_r;
            out_result_den <= (mag_r == 64'd0) ? 62'd1 : drsp.quot[61:0];
            wait_r  <= 1'b0;
            state_r <= S_OUT;
          end
        end
        default: begin
          // S_OUT: hold result until taken
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
      endcase
    end
  end

  `RAU_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, !out_valid)
  `RAU_ASSERT_NXT(a_take_busy, clk, rst_n, in_valid && in_ready, !in_ready)
  `RAU_ASSERT_IMP(a_den_nonzero, clk, rst_n, out_valid, out_result_den != 62'd0)
  `RAU_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_error, out_result_num == 64'sd0)
endmodule

@@ hdl/rau_mult.sv @@
// multicycle 32x32 unsigned multiplier, two 32x16 partial products
// no dependencies
module rau_mult (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] prod
);
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] a_r;
  logic [31:0] b_r;
  logic [1:0]  cnt_r;
  logic        busy_r;
  logic [47:0] pp_r;

  always_comb begin
    acc_nxt = acc_r + ({16'd0, pp_r} << (cnt_r == 2'd2 ? 6'd16 : 6'd0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= !start && busy_r && (cnt_r == 2'd3);
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        busy_r <= 1'b1;
        cnt_r  <= 2'd0;
      end else if (busy_r) begin
        unique case (cnt_r)
          2'd0: begin
            pp_r  <= a_r * b_r[15:0];
            cnt_r <= 2'd1;
          end
          2'd1: begin
            acc_r <= acc_nxt;
            pp_r  <= a_r * b_r[31:16];
            cnt_r <= 2'd2;
          end
          2'd2: begin
            acc_r <= acc_nxt;
            cnt_r <= 2'd3;
          end
          default: begin
            busy_r <= 1'b0;
          end
        endcase
      end
    end
  end
  assign prod = acc_r;
endmodule

@@ hdl/rau_div.sv @@
// radix-2 restoring divider, 64-bit, one quotient bit a cycle
// depends on rau_pkg
module rau_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rau_pkg::div_req_t req,
  output rau_pkg::div_rsp_t rsp
);
  logic [63:0] q_r;
  logic [63:0] r_r;
  logic [63:0] d_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [64:0] trial;
  logic [64:0] shifted;

  always_comb begin
    shifted = {r_r, q_r[63]};
    trial   = shifted - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == 7'd1);
      if (req.start) begin
        q_r    <= req.dividend;
        r_r    <= '0;
        d_r    <= req.divisor;
        cnt_r  <= 7'd64;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!trial[64]) begin
          r_r <= trial[63:0];
          q_r <= {q_r[62:0], 1'b1};
        end else begin
          r_r <= shifted[63:0];
          q_r <= {q_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end
  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = r_r;
endmodule

@@ tb/rational_arithmetic_unit_tb.sv @@
// testbench for the rational arithmetic unit: directed and random fraction items
// depends on rau_pkg and the rational_arithmetic_unit top level
// an internal model predicts each reduced result and the monitor checks it
`timescale 1ns / 100ps
module rational_arithmetic_unit_tb;

  localparam int unsigned NumItems = 1850;
  localparam int unsigned MaxShown = 10;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } frac_item_t;

  typedef struct {
    logic signed [63:0] num;
    logic [61:0]        den;
    logic               greater;
    logic               error;
  } frac_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [2:0] in_command;
  logic signed [31:0] in_first_num;
  logic [30:0] in_first_den;
  logic signed [31:0] in_second_num;
  logic [30:0] in_second_den;
  logic out_valid;
  logic out_ready;
  logic signed [63:0] out_result_num;
  logic [61:0] out_result_den;
  logic out_greater;
  logic out_error;

  frac_item_t   pending_items[$];
  frac_result_t expected_fracs[$];
  int unsigned  items_taken;
  int unsigned  items_seen;
  int unsigned  mismatches;

  rational_arithmetic_unit u_top (.*);

  // free-running clock; the single reset at the start of the run comes from the main sequence
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // euclidean gcd on unsigned magnitudes
  function automatic longint unsigned gcd_mag(longint unsigned x, longint unsigned y);
    longint unsigned r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // lowest terms, sign on the numerator, zero becomes 0/1
  function automatic frac_result_t lowest_terms(longint n, longint d);
    frac_result_t    res;
    longint unsigned mag;
    longint unsigned ud;
    longint unsigned g;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    ud  = d;
    g   = gcd_mag(mag, ud);
    if (g == 0) g = 1;
    mag = mag / g;
    ud  = ud / g;
    if (mag == 0) ud = 1;
    res.num     = (n < 0) ? -$signed(mag) : $signed(mag);
    res.den     = ud[61:0];
    res.greater = 1'b0;
    res.error   = 1'b0;
    return res;
  endfunction

  function automatic frac_result_t predict_fraction(frac_item_t it);
    frac_result_t res;
    longint an;
    longint ad;
    longint bn;
    longint bd;
    an = it.a_num;
    bn = it.b_num;
    ad = (it.a_den == 0) ? 64'sd1 : longint'({33'b0, it.a_den});
    bd = (it.b_den == 0) ? 64'sd1 : longint'({33'b0, it.b_den});
    res = '{num: 64'sd0, den: 62'd1, greater: 1'b0, error: 1'b0};
    case (it.cmd)
      rau_pkg::CMD_ADD: res = lowest_terms(an * bd + bn * ad, ad * bd);
      rau_pkg::CMD_SUB: res = lowest_terms(an * bd - bn * ad, ad * bd);
      rau_pkg::CMD_MUL: res = lowest_terms(an * bn, ad * bd);
      rau_pkg::CMD_DIV: begin
        if (bn == 0) res.error = 1'b1;
        else if (bn < 0) res = lowest_terms(-(an * bd), ad * (-bn));
        else res = lowest_terms(an * bd, ad * bn);
      end
      rau_pkg::CMD_CMP: res.greater = (an * bd > bn * ad);
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic signed [31:0] pick_num();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $signed(32'($urandom_range(0, 200))) - 32'sd100;
    if (sel < 6) return 32'sd0;
    if (sel < 7) return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000001;
    return $signed($urandom());
  endfunction

  function automatic logic [30:0] pick_den();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 11) return 31'($urandom_range(1, 1000));
    if (sel == 11) return 31'd0;
    if (sel == 12) return 31'h7fffffff;
    return 31'($urandom());
  endfunction

  function automatic frac_item_t random_item();
    frac_item_t it;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 4) it.cmd = 3'($urandom_range(rau_pkg::CMD_CMP + 1, 7));
    else it.cmd = 3'($urandom_range(rau_pkg::CMD_ADD, rau_pkg::CMD_CMP));
    it.a_num = pick_num();
    it.a_den = pick_den();
    it.b_num = pick_num();
    it.b_den = pick_den();
    // equal fractions now and then so compare sees ties
    if (sel % 10 == 0) begin
      it.b_num = it.a_num;
      it.b_den = it.a_den;
    end
    return it;
  endfunction

  // directed items: extremes, every command, divide by zero, negative
  // divisor, zero denominators, most negative numerator, unused commands
  task automatic add_directed();
    rau_pkg::cmd_t c;
    c = c.first();
    do begin
      pending_items.push_back('{c, 32'sh7fffffff, 31'd1, 32'sh7fffffff, 31'd1});
      pending_items.push_back('{c, 32'sh80000001, 31'h7fffffff, 32'sh7fffffff, 31'h7ffffffe});
      pending_items.push_back('{c, 32'sh80000000, 31'd3, 32'sh80000000, 31'h7fffffff});
      c = c.next();
    end while (c != c.first());
    pending_items.push_back('{rau_pkg::CMD_DIV, 32'sd5, 31'd7, 32'sd0, 31'd3});
    pending_items.push_back('{rau_pkg::CMD_DIV, 32'sd6, 31'd4, -32'sd9, 31'd2});
    pending_items.push_back('{rau_pkg::CMD_ADD, -32'sd3, 31'd0, 32'sd3, 31'd0});
    pending_items.push_back('{rau_pkg::CMD_MUL, 32'sd0, 31'h7fffffff, -32'sd1, 31'd5});
    pending_items.push_back('{rau_pkg::CMD_CMP, 32'sd1, 31'd2, 32'sd2, 31'd4});
    pending_items.push_back('{rau_pkg::CMD_CMP, 32'sd2, 31'd3, 32'sd1, 31'd2});
    for (int v = rau_pkg::CMD_CMP + 1; v <= 7; v++)
      pending_items.push_back('{3'(v), 32'sd4, 31'd5, 32'sd6, 31'd7});
  endtask

  // idle rates per phase: receiver lazy then sender lazy, then neither
  function automatic bit sender_idles();
    if (items_taken < NumItems / 3) return $urandom_range(0, 99) < 17;
    if (items_taken < 2 * NumItems / 3) return $urandom_range(0, 99) < 88;
    return 1'b0;
  endfunction

  function automatic bit receiver_idles();
    if (items_taken < NumItems / 3) return $urandom_range(0, 99) < 88;
    if (items_taken < 2 * NumItems / 3) return $urandom_range(0, 99) < 17;
    return 1'b0;
  endfunction

  // driver: holds an item until taken, then idles or loads the next
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || items_seen != items_taken) begin
        items_seen = items_taken;
        if (pending_items.size() == 0 || sender_idles()) begin
          in_valid <= 1'b0;
        end else begin
          frac_item_t it;
          it = pending_items.pop_front();
          in_valid      <= 1'b1;
          in_command    <= it.cmd;
          in_first_num  <= it.a_num;
          in_first_den  <= it.a_den;
          in_second_num <= it.b_num;
          in_second_den <= it.b_den;
        end
      end
      out_ready <= !receiver_idles();
    end
  end

  // input side: predict on every item taken
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_fracs.push_back(predict_fraction('{in_command, in_first_num, in_first_den,
                                                  in_second_num, in_second_den}));
      items_taken <= items_taken + 1;
    end
  end

  // output side: compare against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_fracs.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= MaxShown)
          $display("unexpected result %0d/%0d", out_result_num, out_result_den);
      end else begin
        frac_result_t exp_res;
        exp_res = expected_fracs.pop_front();
        if (out_result_num !== exp_res.num || out_result_den !== exp_res.den ||
            out_greater !== exp_res.greater || out_error !== exp_res.error) begin
          mismatches = mismatches + 1;
          if (mismatches <= MaxShown)
            $display("mismatch: expected %0d/%0d g%0b e%0b, got %0d/%0d g%0b e%0b",
                     exp_res.num, exp_res.den, exp_res.greater, exp_res.error,
                     out_result_num, out_result_den, out_greater, out_error);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_command = '0;
    in_first_num = '0;
    in_first_den = '0;
    in_second_num = '0;
    in_second_den = '0;
    items_taken = 0;
    items_seen = 0;
    mismatches = 0;
    add_directed();
    while (pending_items.size() < NumItems) pending_items.push_back(random_item());
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    while (pending_items.size() != 0 || in_valid || expected_fracs.size() != 0)
      @(posedge clk);
    // long gcd runs: give any stray result time to show
    repeat (8000) @(posedge clk);
    if (mismatches == 0 && expected_fracs.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
